FILE: rtl/core/eevdf_task_selector_assert.svh
// ---------------------------------------------------------------------------
// eevdf task selector assertion macros
// clocked property checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef EEVDF_TASK_SELECTOR_ASSERT_SVH
`define EEVDF_TASK_SELECTOR_ASSERT_SVH

`ifndef SYNTHESIS
// property checked at every edge outside reset
`define EVS_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("eevdf task selector check failed");
// property checked at every edge, reset included
`define EVS_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("eevdf task selector check failed");
`else
`define EVS_ASSERT(name, prop)
`define EVS_ASSERT_ALWAYS(name, prop)
`endif

`endif

FILE: rtl/core/eevdf_pkg.sv
// ---------------------------------------------------------------------------
// eevdf package
// shared types, codes and the nice-to-weight table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package eevdf_pkg;

    // item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ACCT   = 2'd1;
    localparam logic [1:0] KIND_SELECT = 2'd2;

    // slot status codes
    localparam logic [1:0] STAT_INACTIVE = 2'd0;
    localparam logic [1:0] STAT_RUNNABLE = 2'd1;
    localparam logic [1:0] STAT_RUNNING  = 2'd2;

    // configuration register indexes
    localparam logic CFG_BASE_SLICE   = 1'b0;
    localparam logic CFG_TIME_DIVISOR = 1'b1;

    localparam logic [15:0] BASE_SLICE_RST   = 16'd5000;
    localparam logic [15:0] TIME_DIVISOR_RST = 16'd100;
    localparam logic [5:0]  NICE_NEUTRAL     = 6'd20;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  nice;
        logic [63:0] vruntime;
        logic [63:0] vdeadline;
        logic        eligible;
    } slot_entry_t;

    // busy/done status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_DIV,
        S_AC_RD,
        S_AC_DIV1,
        S_AC_DIV2,
        S_P1_RD,
        S_P1_EV,
        S_P2_RD,
        S_P2_EV,
        S_P2_MUL,
        S_P3_RD,
        S_P3_EV,
        S_P3_MUL,
        S_PK_ISS,
        S_PK_RD,
        S_DONE
    } state_t;

    // load weight per nice level, index saturates at the top entry
    function automatic logic [16:0] weight_of(input logic [5:0] nice);
        logic [16:0] w;
        case (nice)
            6'd0:  w = 17'd88761;
            6'd1:  w = 17'd71755;
            6'd2:  w = 17'd56483;
            6'd3:  w = 17'd46273;
            6'd4:  w = 17'd36291;
            6'd5:  w = 17'd29154;
            6'd6:  w = 17'd23254;
            6'd7:  w = 17'd18705;
            6'd8:  w = 17'd14949;
            6'd9:  w = 17'd11916;
            6'd10: w = 17'd9548;
            6'd11: w = 17'd7620;
            6'd12: w = 17'd6100;
            6'd13: w = 17'd4904;
            6'd14: w = 17'd3906;
            6'd15: w = 17'd3121;
            6'd16: w = 17'd2501;
            6'd17: w = 17'd1991;
            6'd18: w = 17'd1586;
            6'd19: w = 17'd1277;
            6'd20: w = 17'd1024;
            6'd21: w = 17'd820;
            6'd22: w = 17'd655;
            6'd23: w = 17'd526;
            6'd24: w = 17'd423;
            6'd25: w = 17'd335;
            6'd26: w = 17'd272;
            6'd27: w = 17'd215;
            6'd28: w = 17'd172;
            6'd29: w = 17'd137;
            6'd30: w = 17'd110;
            6'd31: w = 17'd87;
            6'd32: w = 17'd70;
            6'd33: w = 17'd56;
            6'd34: w = 17'd45;
            6'd35: w = 17'd36;
            6'd36: w = 17'd29;
            6'd37: w = 17'd23;
            6'd38: w = 17'd18;
            default: w = 17'd15;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/eevdf_mem.sv
// ---------------------------------------------------------------------------
// eevdf slot memory
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module eevdf_mem #(
    parameter int SLOTS = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
    input  eevdf_pkg::slot_entry_t               wdata,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
    output eevdf_pkg::slot_entry_t               rdata
);

    eevdf_pkg::slot_entry_t mem [SLOTS];
    eevdf_pkg::slot_entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/eevdf_mul.sv
// ---------------------------------------------------------------------------
// eevdf multiplier
// 64 x 32 product modulo 2^64 from two 32 x 32 partials on one shared multiplier
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module eevdf_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [63:0]            a,
    input  logic [31:0]            b,
    output logic [63:0]            product,
    output eevdf_pkg::unit_stat_t  stat
);

    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] a_reg;
    logic [31:0] b_reg;
    logic [63:0] plo_reg;
    logic [31:0] phi_reg;
    logic [63:0] res_reg;
    logic [31:0] op_a;
    logic [63:0] prod;

    // one shared 32 x 32 multiplier
    assign op_a = (phase_reg == 2'd0) ? a_reg[31:0] : a_reg[63:32];
    assign prod = op_a * b_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (phase_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    // partial products and final sum
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            case (phase_reg)
                2'd0:    plo_reg <= prod;
                2'd1:    phi_reg <= prod[31:0];
                default: res_reg <= plo_reg + {phi_reg, 32'd0};
            endcase
        end
    end

    assign product   = res_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/core/eevdf_div.sv
// ---------------------------------------------------------------------------
// eevdf divider
// restoring 64 / 17 bit division, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module eevdf_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [63:0]            dividend,
    input  logic [16:0]            divisor,
    output logic [63:0]            quotient,
    output eevdf_pkg::unit_stat_t  stat
);

    logic [63:0] q_reg;
    logic [16:0] r_reg;
    logic [16:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [17:0] rs;
    logic        ge;
    logic [16:0] r_next;

    // one restoring step
    assign rs     = {r_reg, q_reg[63]};
    assign ge     = (rs >= {1'b0, d_reg});
    assign r_next = ge ? 17'(rs - {1'b0, d_reg}) : 17'(rs);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= 17'd0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[62:0], ge};
            r_reg <= r_next;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/core/eevdf_task_selector.sv
// ---------------------------------------------------------------------------
// eevdf task selector
// slot table with virtual runtime accounting and earliest eligible
// virtual deadline selection
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  kind slot run_state nice_level
//                                           vruntime_in elapsed_time
//  out      output     out_valid/out_ready  found slot_out vruntime_out
//                                           vdeadline_out eligible_out
//  cfg      input      cfg_we               cfg_index cfg_data
//
//  load and account are both paced by the bit-serial divider; select makes
//  three sweeps over the slot memory, the last two with the multiplier.
//  after reset a clearing pass writes every slot, in_ready stays low
//  meanwhile. one item at a time; the next is taken while a result still
//  waits in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "eevdf_task_selector_assert.svh"

module eevdf_task_selector #(
    parameter int SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [5:0]  slot,
    input  logic [1:0]  run_state,
    input  logic [5:0]  nice_level,
    input  logic [63:0] vruntime_in,
    input  logic [31:0] elapsed_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [5:0]  slot_out,
    output logic [63:0] vruntime_out,
    output logic [63:0] vdeadline_out,
    output logic        eligible_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WSUM_W = 18 + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    eevdf_pkg::state_t state_reg;
    eevdf_pkg::state_t state_next;

    logic [15:0] base_slice_reg;
    logic [15:0] time_divisor_reg;

    // captured item
    logic [1:0]  run_state_reg;
    logic [5:0]  nice_reg;
    logic [5:0]  slot_reg;
    logic [63:0] vr_in_reg;
    logic [31:0] elapsed_reg;

    // sweep state
    logic [IW-1:0]     idx_reg;
    logic [63:0]       v0_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [63:0]       lag_reg;
    eevdf_pkg::slot_entry_t ent_reg;
    logic              have_reg;
    logic [IW-1:0]     pick_reg;
    logic [63:0]       best_vd_reg;
    logic              fb_have_reg;
    logic [IW-1:0]     fb_pick_reg;
    logic [63:0]       fb_vd_reg;

    // pending result and output register
    logic        res_found_reg;
    logic [5:0]  res_slot_reg;
    logic [63:0] res_vr_reg;
    logic [63:0] res_vd_reg;
    logic        res_elig_reg;
    logic        out_valid_reg;
    logic        found_reg;
    logic [5:0]  slot_out_reg;
    logic [63:0] vr_out_reg;
    logic [63:0] vd_out_reg;
    logic        elig_out_reg;

    // memory and unit hookup
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    eevdf_pkg::slot_entry_t mem_wdata;
    logic [IW-1:0]          mem_raddr;
    eevdf_pkg::slot_entry_t mem_rdata;
    logic                   div_start;
    logic [63:0]            div_dividend;
    logic [16:0]            div_divisor;
    logic [63:0]            div_q;
    eevdf_pkg::unit_stat_t  div_stat;
    logic                   mul_start;
    logic [63:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;
    eevdf_pkg::unit_stat_t  mul_stat;

    logic          in_beat;
    logic          in_range;
    logic          rd_active;
    logic          ent_elig;
    logic          out_load;
    logic [IW-1:0] pick_sel;
    logic [16:0]   ent_w;

    assign in_beat   = in_valid && in_ready;
    assign in_range  = (32'(slot) < SLOTS);
    assign rd_active = (mem_rdata.status == eevdf_pkg::STAT_RUNNABLE)
                    || (mem_rdata.status == eevdf_pkg::STAT_RUNNING);
    assign ent_elig  = (lag_reg >= mul_p);
    assign out_load  = (state_reg == eevdf_pkg::S_DONE) && (!out_valid_reg || out_ready);
    assign pick_sel  = have_reg ? pick_reg : fb_pick_reg;
    assign ent_w     = eevdf_pkg::weight_of(ent_reg.nice);

    eevdf_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    eevdf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .stat     (div_stat)
    );

    eevdf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p),
        .stat    (mul_stat)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_slice_reg   <= eevdf_pkg::BASE_SLICE_RST;
            time_divisor_reg <= eevdf_pkg::TIME_DIVISOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eevdf_pkg::CFG_BASE_SLICE:   base_slice_reg   <= cfg_data;
                eevdf_pkg::CFG_TIME_DIVISOR: time_divisor_reg <= cfg_data;
                default:                     base_slice_reg   <= base_slice_reg;
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eevdf_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, memory and unit controls
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = ent_reg;
        mem_raddr    = idx_reg;
        div_start    = 1'b0;
        div_dividend = 64'd0;
        div_divisor  = 17'd1;
        mul_start    = 1'b0;
        mul_a        = mem_rdata.vruntime - v0_reg;
        mul_b        = 32'(eevdf_pkg::weight_of(mem_rdata.nice));
        case (state_reg)
            eevdf_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{status: eevdf_pkg::STAT_INACTIVE,
                              nice: eevdf_pkg::NICE_NEUTRAL,
                              vruntime: 64'd0, vdeadline: 64'd0, eligible: 1'b1};
                if (idx_reg == LAST_IDX)
                begin
                    state_next = eevdf_pkg::S_IDLE;
                end
            end
            eevdf_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = IW'(slot);
                if (in_beat)
                begin
                    if (kind == eevdf_pkg::KIND_LOAD && in_range)
                    begin
                        div_start    = 1'b1;
                        div_dividend = 64'({base_slice_reg, 10'd0});
                        div_divisor  = eevdf_pkg::weight_of(nice_level);
                        state_next   = eevdf_pkg::S_LD_DIV;
                    end
                    else if (kind == eevdf_pkg::KIND_ACCT && in_range)
                    begin
                        state_next = eevdf_pkg::S_AC_RD;
                    end
                    else if (kind == eevdf_pkg::KIND_SELECT)
                    begin
                        state_next = eevdf_pkg::S_P1_RD;
                    end
                    else
                    begin
                        state_next = eevdf_pkg::S_DONE;
                    end
                end
            end
            eevdf_pkg::S_LD_DIV:
            begin
                mem_waddr = IW'(slot_reg);
                mem_wdata = '{status: run_state_reg, nice: nice_reg,
                              vruntime: vr_in_reg, vdeadline: vr_in_reg + div_q,
                              eligible: 1'b1};
                if (div_stat.done)
                begin
                    mem_we     = 1'b1;
                    state_next = eevdf_pkg::S_DONE;
                end
            end
            eevdf_pkg::S_AC_RD:
            begin
                div_start    = 1'b1;
                div_dividend = 64'(elapsed_reg);
                div_divisor  = (time_divisor_reg == 16'd0) ? 17'd1 : 17'(time_divisor_reg);
                state_next   = eevdf_pkg::S_AC_DIV1;
            end
            eevdf_pkg::S_AC_DIV1:
            begin
                if (div_stat.done)
                begin
                    div_start    = 1'b1;
                    div_dividend = {div_q[53:0], 10'd0};
                    div_divisor  = ent_w;
                    state_next   = eevdf_pkg::S_AC_DIV2;
                end
            end
            eevdf_pkg::S_AC_DIV2:
            begin
                mem_waddr          = IW'(slot_reg);
                mem_wdata.vruntime = ent_reg.vruntime + div_q;
                if (div_stat.done)
                begin
                    mem_we     = 1'b1;
                    state_next = eevdf_pkg::S_DONE;
                end
            end
            eevdf_pkg::S_P1_RD:
            begin
                state_next = eevdf_pkg::S_P1_EV;
            end
            eevdf_pkg::S_P1_EV:
            begin
                state_next = (idx_reg == LAST_IDX) ? eevdf_pkg::S_P2_RD : eevdf_pkg::S_P1_RD;
            end
            eevdf_pkg::S_P2_RD:
            begin
                state_next = eevdf_pkg::S_P2_EV;
            end
            eevdf_pkg::S_P2_EV:
            begin
                if (rd_active)
                begin
                    mul_start  = 1'b1;
                    state_next = eevdf_pkg::S_P2_MUL;
                end
                else
                begin
                    state_next = (idx_reg == LAST_IDX) ? eevdf_pkg::S_P3_RD
                                                       : eevdf_pkg::S_P2_RD;
                end
            end
            eevdf_pkg::S_P2_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = (idx_reg == LAST_IDX) ? eevdf_pkg::S_P3_RD
                                                       : eevdf_pkg::S_P2_RD;
                end
            end
            eevdf_pkg::S_P3_RD:
            begin
                state_next = eevdf_pkg::S_P3_EV;
            end
            eevdf_pkg::S_P3_EV:
            begin
                mul_b = 32'(wsum_reg);
                if (mem_rdata.status == eevdf_pkg::STAT_RUNNABLE)
                begin
                    mul_start  = 1'b1;
                    state_next = eevdf_pkg::S_P3_MUL;
                end
                else
                begin
                    state_next = (idx_reg == LAST_IDX) ? eevdf_pkg::S_PK_ISS
                                                       : eevdf_pkg::S_P3_RD;
                end
            end
            eevdf_pkg::S_P3_MUL:
            begin
                mem_wdata.eligible = ent_elig;
                if (mul_stat.done)
                begin
                    mem_we     = 1'b1;
                    state_next = (idx_reg == LAST_IDX) ? eevdf_pkg::S_PK_ISS
                                                       : eevdf_pkg::S_P3_RD;
                end
            end
            eevdf_pkg::S_PK_ISS:
            begin
                mem_raddr  = pick_sel;
                state_next = fb_have_reg ? eevdf_pkg::S_PK_RD : eevdf_pkg::S_DONE;
            end
            eevdf_pkg::S_PK_RD:
            begin
                mem_we           = 1'b1;
                mem_waddr        = pick_sel;
                mem_wdata        = mem_rdata;
                mem_wdata.status = eevdf_pkg::STAT_RUNNING;
                state_next       = eevdf_pkg::S_DONE;
            end
            eevdf_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = eevdf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = eevdf_pkg::S_IDLE;
            end
        endcase
    end

    // sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (state_reg == eevdf_pkg::S_CLEAR
              || state_reg == eevdf_pkg::S_P1_EV
              || (state_reg == eevdf_pkg::S_P2_EV && !rd_active)
              || (state_reg == eevdf_pkg::S_P2_MUL && mul_stat.done)
              || (state_reg == eevdf_pkg::S_P3_EV
                  && mem_rdata.status != eevdf_pkg::STAT_RUNNABLE)
              || (state_reg == eevdf_pkg::S_P3_MUL && mul_stat.done))
        begin
            idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
        end
    end

    // item capture and sweep datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            eevdf_pkg::S_IDLE:
            begin
                if (in_beat)
                begin
                    run_state_reg <= run_state;
                    nice_reg      <= nice_level;
                    slot_reg      <= slot;
                    vr_in_reg     <= vruntime_in;
                    elapsed_reg   <= elapsed_time;
                    v0_reg        <= '1;
                    wsum_reg      <= '0;
                    lag_reg       <= 64'd0;
                    have_reg      <= 1'b0;
                    fb_have_reg   <= 1'b0;
                    res_found_reg <= 1'b0;
                    res_slot_reg  <= (kind == eevdf_pkg::KIND_SELECT) ? 6'd0 : slot;
                    res_vr_reg    <= 64'd0;
                    res_vd_reg    <= 64'd0;
                    res_elig_reg  <= 1'b0;
                end
            end
            eevdf_pkg::S_LD_DIV:
            begin
                res_found_reg <= 1'b1;
                res_vr_reg    <= vr_in_reg;
                res_vd_reg    <= vr_in_reg + div_q;
                res_elig_reg  <= 1'b1;
            end
            eevdf_pkg::S_AC_RD:
            begin
                ent_reg <= mem_rdata;
            end
            eevdf_pkg::S_AC_DIV2:
            begin
                res_found_reg <= 1'b1;
                res_vr_reg    <= ent_reg.vruntime + div_q;
                res_vd_reg    <= ent_reg.vdeadline;
                res_elig_reg  <= ent_reg.eligible;
            end
            eevdf_pkg::S_P1_EV:
            begin
                if (rd_active && mem_rdata.vruntime < v0_reg)
                begin
                    v0_reg <= mem_rdata.vruntime;
                end
            end
            eevdf_pkg::S_P2_EV:
            begin
                if (rd_active)
                begin
                    wsum_reg <= wsum_reg + WSUM_W'(eevdf_pkg::weight_of(mem_rdata.nice));
                end
            end
            eevdf_pkg::S_P2_MUL:
            begin
                if (mul_stat.done)
                begin
                    lag_reg <= lag_reg + mul_p;
                end
            end
            eevdf_pkg::S_P3_EV:
            begin
                ent_reg <= mem_rdata;
            end
            eevdf_pkg::S_P3_MUL:
            begin
                if (mul_stat.done)
                begin
                    // fallback: least deadline over all runnable slots
                    if (!fb_have_reg || ent_reg.vdeadline < fb_vd_reg)
                    begin
                        fb_have_reg <= 1'b1;
                        fb_pick_reg <= idx_reg;
                        fb_vd_reg   <= ent_reg.vdeadline;
                    end
                    // least deadline over eligible runnable slots
                    if (ent_elig && (!have_reg || ent_reg.vdeadline < best_vd_reg))
                    begin
                        have_reg    <= 1'b1;
                        pick_reg    <= idx_reg;
                        best_vd_reg <= ent_reg.vdeadline;
                    end
                end
            end
            eevdf_pkg::S_PK_RD:
            begin
                res_found_reg <= 1'b1;
                res_slot_reg  <= 6'(pick_sel);
                res_vr_reg    <= mem_rdata.vruntime;
                res_vd_reg    <= mem_rdata.vdeadline;
                res_elig_reg  <= mem_rdata.eligible;
            end
            default:
            begin
                ent_reg <= ent_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found_reg    <= res_found_reg;
            slot_out_reg <= res_slot_reg;
            vr_out_reg   <= res_vr_reg;
            vd_out_reg   <= res_vd_reg;
            elig_out_reg <= res_elig_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign slot_out      = slot_out_reg;
    assign vruntime_out  = vr_out_reg;
    assign vdeadline_out = vd_out_reg;
    assign eligible_out  = elig_out_reg;

    // checks
    `EVS_ASSERT(a_no_write_idle, (state_reg == eevdf_pkg::S_IDLE) |-> !mem_we)
    `EVS_ASSERT(a_units_exclusive, !(div_stat.busy && mul_stat.busy))
    `EVS_ASSERT(a_div_done_pulse, div_stat.done |=> !div_stat.done)
    `EVS_ASSERT_ALWAYS(a_clear_blocks_input, (state_reg == eevdf_pkg::S_CLEAR) |-> !in_ready)

endmodule

FILE: tb/eevdf_selector_checker.sv
// ---------------------------------------------------------------------------
// eevdf task selector checker
// watches the item and result channels, keeps its own copy of the slot
// table and compares every result beat with the predicted one
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module eevdf_selector_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [5:0]  slot,
    input  logic [1:0]  run_state,
    input  logic [5:0]  nice_level,
    input  logic [63:0] vruntime_in,
    input  logic [31:0] elapsed_time,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        found,
    input  logic [5:0]  slot_out,
    input  logic [63:0] vruntime_out,
    input  logic [63:0] vdeadline_out,
    input  logic        eligible_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    localparam int NSLOTS = 64;

    typedef struct packed {
        logic        found;
        logic [5:0]  slot;
        logic [63:0] vruntime;
        logic [63:0] vdeadline;
        logic        eligible;
    } sched_result_t;

    // shadow table and registers
    logic [1:0]  tbl_status    [NSLOTS];
    logic [5:0]  tbl_nice      [NSLOTS];
    logic [63:0] tbl_vruntime  [NSLOTS];
    logic [63:0] tbl_vdeadline [NSLOTS];
    logic        tbl_eligible  [NSLOTS];
    logic [15:0] slice_reg;
    logic [15:0] divisor_reg;

    sched_result_t awaited_results[$];

    function automatic logic [63:0] nice_weight(input logic [5:0] n);
        logic [63:0] w;
        case (n > 6'd39 ? 6'd39 : n)
            6'd0:  w = 88761; 6'd1:  w = 71755; 6'd2:  w = 56483; 6'd3:  w = 46273;
            6'd4:  w = 36291; 6'd5:  w = 29154; 6'd6:  w = 23254; 6'd7:  w = 18705;
            6'd8:  w = 14949; 6'd9:  w = 11916; 6'd10: w = 9548;  6'd11: w = 7620;
            6'd12: w = 6100;  6'd13: w = 4904;  6'd14: w = 3906;  6'd15: w = 3121;
            6'd16: w = 2501;  6'd17: w = 1991;  6'd18: w = 1586;  6'd19: w = 1277;
            6'd20: w = 1024;  6'd21: w = 820;   6'd22: w = 655;   6'd23: w = 526;
            6'd24: w = 423;   6'd25: w = 335;   6'd26: w = 272;   6'd27: w = 215;
            6'd28: w = 172;   6'd29: w = 137;   6'd30: w = 110;   6'd31: w = 87;
            6'd32: w = 70;    6'd33: w = 56;    6'd34: w = 45;    6'd35: w = 36;
            6'd36: w = 29;    6'd37: w = 23;    6'd38: w = 18;    default: w = 15;
        endcase
        return w;
    endfunction

    function automatic sched_result_t slot_view(input logic f, input int i);
        sched_result_t r;
        r.found     = f;
        r.slot      = i[5:0];
        r.vruntime  = tbl_vruntime[i];
        r.vdeadline = tbl_vdeadline[i];
        r.eligible  = tbl_eligible[i];
        return r;
    endfunction

    // earliest eligible virtual deadline pick
    function automatic sched_result_t pick_next_task();
        logic [63:0] v0;
        logic [63:0] wsum;
        logic [63:0] lagsum;
        logic [63:0] w;
        bit          have;
        int          pick;
        sched_result_t r;
        v0 = '1;
        wsum = 0;
        lagsum = 0;
        have = 0;
        pick = 0;
        for (int i = 0; i < NSLOTS; i++)
            if ((tbl_status[i] == eevdf_pkg::STAT_RUNNABLE
                 || tbl_status[i] == eevdf_pkg::STAT_RUNNING)
                && tbl_vruntime[i] < v0)
                v0 = tbl_vruntime[i];
        for (int i = 0; i < NSLOTS; i++)
            if (tbl_status[i] == eevdf_pkg::STAT_RUNNABLE
                || tbl_status[i] == eevdf_pkg::STAT_RUNNING)
            begin
                w = nice_weight(tbl_nice[i]);
                wsum += w;
                lagsum += (tbl_vruntime[i] - v0) * w;
            end
        for (int i = 0; i < NSLOTS; i++)
            if (tbl_status[i] == eevdf_pkg::STAT_RUNNABLE)
            begin
                tbl_eligible[i] = (lagsum >= (tbl_vruntime[i] - v0) * wsum);
                if (tbl_eligible[i] && (!have || tbl_vdeadline[i] < tbl_vdeadline[pick]))
                begin
                    have = 1;
                    pick = i;
                end
            end
        // fallback: least deadline among all runnable slots
        if (!have)
            for (int i = 0; i < NSLOTS; i++)
                if (tbl_status[i] == eevdf_pkg::STAT_RUNNABLE
                    && (!have || tbl_vdeadline[i] < tbl_vdeadline[pick]))
                begin
                    have = 1;
                    pick = i;
                end
        if (!have)
        begin
            r = '0;
            return r;
        end
        tbl_status[pick] = eevdf_pkg::STAT_RUNNING;
        return slot_view(1'b1, pick);
    endfunction

    function automatic sched_result_t apply_item();
        int          i;
        logic [63:0] div;
        sched_result_t r;
        i = slot;
        case (kind)
            eevdf_pkg::KIND_LOAD:
            begin
                tbl_status[i]    = run_state;
                tbl_nice[i]      = nice_level;
                tbl_vruntime[i]  = vruntime_in;
                tbl_vdeadline[i] = vruntime_in
                    + 64'(slice_reg) * 1024 / nice_weight(nice_level);
                tbl_eligible[i]  = 1'b1;
                return slot_view(1'b1, i);
            end
            eevdf_pkg::KIND_ACCT:
            begin
                div = (divisor_reg == 0) ? 64'd1 : 64'(divisor_reg);
                tbl_vruntime[i] += (64'(elapsed_time) / div) * 1024
                    / nice_weight(tbl_nice[i]);
                return slot_view(1'b1, i);
            end
            eevdf_pkg::KIND_SELECT: return pick_next_task();
            default:
            begin
                r = '0;
                r.slot = slot;
                return r;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending_count = awaited_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOTS; i++)
            begin
                tbl_status[i]    = eevdf_pkg::STAT_INACTIVE;
                tbl_nice[i]      = eevdf_pkg::NICE_NEUTRAL;
                tbl_vruntime[i]  = 0;
                tbl_vdeadline[i] = 0;
                tbl_eligible[i]  = 1'b1;
            end
            slice_reg   = eevdf_pkg::BASE_SLICE_RST;
            divisor_reg = eevdf_pkg::TIME_DIVISOR_RST;
            awaited_results.delete();
            fail_count = 0;
        end
        else
        begin
            // result beat
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("[%0t] unexpected result beat", $realtime);
                    fail_count++;
                end
                else
                begin
                    e = awaited_results.pop_front();
                    if (found !== e.found) report_mismatch("found", 64'(found), 64'(e.found));
                    if (slot_out !== e.slot) report_mismatch("slot", 64'(slot_out), 64'(e.slot));
                    if (vruntime_out !== e.vruntime)
                        report_mismatch("vruntime", vruntime_out, e.vruntime);
                    if (vdeadline_out !== e.vdeadline)
                        report_mismatch("vdeadline", vdeadline_out, e.vdeadline);
                    if (eligible_out !== e.eligible)
                        report_mismatch("eligible", 64'(eligible_out), 64'(e.eligible));
                end
            end
            // register write
            if (cfg_we)
            begin
                if (cfg_index == eevdf_pkg::CFG_BASE_SLICE) slice_reg = cfg_data;
                else divisor_reg = cfg_data;
            end
            // item beat
            if (in_valid && in_ready)
                awaited_results.push_back(apply_item());
        end
    end

endmodule

FILE: tb/tb_eevdf_task_selector.sv
// ---------------------------------------------------------------------------
// eevdf task selector testbench
// directed and random load, account and select items under random idling
// on both channels, with register changes between phases
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_eevdf_task_selector;

    localparam logic [1:0] KIND_RSVD = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [1:0]  run_state;
    logic [5:0]  nice_level;
    logic [63:0] vruntime_in;
    logic [31:0] elapsed_time;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [5:0]  slot_out;
    logic [63:0] vruntime_out;
    logic [63:0] vdeadline_out;
    logic        eligible_out;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending_count;
    bit          calm;

    eevdf_task_selector uut (.*);
    eevdf_selector_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= calm || ($urandom_range(99) >= 29);
    end

    // valid stays high after a beat until the next idle or the next item
    task automatic send_beat(input logic [1:0] k, input logic [5:0] s,
                             input logic [1:0] st, input logic [5:0] n,
                             input logic [63:0] v, input logic [31:0] el);
        while (!calm && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        slot         <= s;
        run_state    <= st;
        nice_level   <= n;
        vruntime_in  <= v;
        elapsed_time <= el;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_and_write(input logic idx, input logic [15:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand_vrt(input int mode);
        case (mode)
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(4000));
            default: return 64'hFFFF_FFFF_FFFF_0000 + 64'($urandom_range(65535));
        endcase
    endfunction

    task automatic random_phase(input int count);
        int r;
        int vmode;
        vmode = $urandom_range(2);
        for (int n = 0; n < count; n++)
        begin
            calm = (n >= count / 2 && n < count / 2 + 40);
            r = $urandom_range(99);
            if (r < 40)
                send_beat(eevdf_pkg::KIND_LOAD, 6'($urandom_range(63)),
                          ($urandom_range(3) == 0) ? 2'($urandom_range(3))
                                                   : eevdf_pkg::STAT_RUNNABLE,
                          ($urandom_range(9) == 0) ? 6'($urandom_range(63, 40))
                                                   : 6'($urandom_range(39)),
                          ($urandom_range(9) == 0) ? rand_vrt(0) : rand_vrt(vmode), 32'd0);
            else if (r < 70)
                send_beat(eevdf_pkg::KIND_ACCT, 6'($urandom_range(63)), 2'($urandom),
                          6'($urandom), 64'({$urandom, $urandom}),
                          ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(200000)));
            else if (r < 97)
                send_beat(eevdf_pkg::KIND_SELECT, 6'($urandom), 2'($urandom), 6'($urandom),
                          64'({$urandom, $urandom}), $urandom);
            else
                send_beat(KIND_RSVD, 6'($urandom), 2'($urandom), 6'($urandom),
                          64'({$urandom, $urandom}), $urandom);
        end
        calm = 0;
    endtask

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        calm         = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = eevdf_pkg::KIND_LOAD;
        slot         = '0;
        run_state    = '0;
        nice_level   = '0;
        vruntime_in  = '0;
        elapsed_time = '0;
        cfg_we       = 1'b0;
        cfg_index    = eevdf_pkg::CFG_BASE_SLICE;
        cfg_data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty select, field extremes, reserved kind
        send_beat(eevdf_pkg::KIND_SELECT, 6'd0, eevdf_pkg::STAT_INACTIVE, 6'd0, '0, '0);
        send_beat(eevdf_pkg::KIND_LOAD, 6'd0, eevdf_pkg::STAT_RUNNABLE, 6'd0, 64'd0, 32'd0);
        send_beat(eevdf_pkg::KIND_LOAD, 6'd63, eevdf_pkg::STAT_RUNNABLE, 6'd39, '1, '1);
        send_beat(eevdf_pkg::KIND_LOAD, 6'd5, eevdf_pkg::STAT_RUNNING, 6'd63, 64'd100, 32'd0);
        send_beat(eevdf_pkg::KIND_LOAD, 6'd6, 2'd3, 6'd20, 64'd50, 32'd0);
        send_beat(eevdf_pkg::KIND_LOAD, 6'd7, eevdf_pkg::STAT_RUNNABLE, 6'd20, 64'd0, 32'd0);
        send_beat(eevdf_pkg::KIND_ACCT, 6'd0, 2'd0, 6'd0, '0, '1);
        send_beat(eevdf_pkg::KIND_ACCT, 6'd6, 2'd0, 6'd0, '0, 32'd12345);
        send_beat(eevdf_pkg::KIND_ACCT, 6'd63, 2'd3, 6'd63, '1, 32'd0);
        send_beat(KIND_RSVD, 6'd63, 2'd3, 6'd63, '1, '1);
        send_beat(eevdf_pkg::KIND_SELECT, 6'd0, 2'd0, 6'd0, '0, '0);
        send_beat(eevdf_pkg::KIND_SELECT, 6'd0, 2'd0, 6'd0, '0, '0);
        send_beat(eevdf_pkg::KIND_SELECT, 6'd0, 2'd0, 6'd0, '0, '0);
        send_beat(eevdf_pkg::KIND_SELECT, 6'd0, 2'd0, 6'd0, '0, '0);

        // register extremes, divisor of zero acts as one
        drain_and_write(eevdf_pkg::CFG_TIME_DIVISOR, 16'd0);
        drain_and_write(eevdf_pkg::CFG_BASE_SLICE, 16'hFFFF);
        send_beat(eevdf_pkg::KIND_LOAD, 6'd9, eevdf_pkg::STAT_RUNNABLE, 6'd0, 64'd10, 32'd0);
        send_beat(eevdf_pkg::KIND_ACCT, 6'd9, 2'd0, 6'd0, '0, '1);
        send_beat(eevdf_pkg::KIND_SELECT, 6'd0, 2'd0, 6'd0, '0, '0);
        random_phase(150);

        drain_and_write(eevdf_pkg::CFG_BASE_SLICE, 16'd1);
        drain_and_write(eevdf_pkg::CFG_TIME_DIVISOR, 16'hFFFF);
        random_phase(150);

        drain_and_write(eevdf_pkg::CFG_BASE_SLICE, 16'($urandom_range(1, 65535)));
        drain_and_write(eevdf_pkg::CFG_TIME_DIVISOR, 16'($urandom_range(1, 65535)));
        random_phase(150);

        drain_and_write(eevdf_pkg::CFG_BASE_SLICE, 16'd5000);
        drain_and_write(eevdf_pkg::CFG_TIME_DIVISOR, 16'd1);
        random_phase(180);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
